### src/tcf_pkg.sv
// ----------------------------------------------------------------------------
// tcf_pkg
// Shared types, constants and the arctangent table of the tilt filter.
// ----------------------------------------------------------------------------
package tcf_pkg;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int TABLE_LEN        = 24;
   localparam int IDX_W            = 5;
   localparam int CORDIC_W         = 28;
   localparam int ANGLE_W          = 25;
   localparam int INC_W            = 29;
   localparam int CSR_IDX_W        = 2;
   localparam int CSR_DATA_W       = 17;

   localparam logic [CSR_IDX_W-1:0] CSR_BLEND  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_PERIOD = 2'd1;

   typedef struct packed {
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic signed [15:0] gyro_x;
      logic signed [15:0] gyro_y;
   } tcf_req_type;

   typedef struct packed {
      logic signed [23:0] roll_angle;
      logic signed [23:0] pitch_angle;
   } tcf_rsp_type;

   // atan(2^-i) in q16 degrees
   function automatic logic [21:0] atan_q16(input logic [IDX_W-1:0] idx);
      logic [21:0] v;
      unique case (idx)
         5'd0:  v = 22'd2949120;
         5'd1:  v = 22'd1740967;
         5'd2:  v = 22'd919879;
         5'd3:  v = 22'd466945;
         5'd4:  v = 22'd234379;
         5'd5:  v = 22'd117304;
         5'd6:  v = 22'd58666;
         5'd7:  v = 22'd29335;
         5'd8:  v = 22'd14668;
         5'd9:  v = 22'd7334;
         5'd10: v = 22'd3667;
         5'd11: v = 22'd1833;
         5'd12: v = 22'd917;
         5'd13: v = 22'd458;
         5'd14: v = 22'd229;
         5'd15: v = 22'd115;
         5'd16: v = 22'd57;
         5'd17: v = 22'd29;
         5'd18: v = 22'd14;
         5'd19: v = 22'd7;
         5'd20: v = 22'd4;
         5'd21: v = 22'd2;
         5'd22: v = 22'd1;
         default: v = 22'd0;
      endcase
      return v;
   endfunction

endpackage

### src/tcf_cordic.sv
// ----------------------------------------------------------------------------
// tcf_cordic
// Vectoring CORDIC, one rotation per cycle, angle in q16 degrees.
// ----------------------------------------------------------------------------
module tcf_cordic #(
   parameter int STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [tcf_pkg::CORDIC_W-1:0]  x_start,
   input  logic signed [tcf_pkg::CORDIC_W-1:0]  y_start,
   output logic                                 busy,
   output logic                                 done,
   output logic signed [tcf_pkg::CORDIC_W-1:0]  x_out,
   output logic signed [tcf_pkg::ANGLE_W-1:0]   z_out
);
   import tcf_pkg::*;

   localparam int N  = (STEPS > TABLE_LEN) ? TABLE_LEN : STEPS;
   localparam int IW = $clog2(N);

   logic signed [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in;
   logic signed [ANGLE_W-1:0]  z_ff, z_in;
   logic [IW-1:0]              idx_ff, idx_in;
   logic                       busy_ff, busy_in, done_ff, done_in;
   logic signed [ANGLE_W-1:0]  step_ang;

   assign step_ang = $signed({3'b000, atan_q16(IDX_W'(idx_ff))});

   always_comb begin
      x_in    = x_ff;
      y_in    = y_ff;
      z_in    = z_ff;
      idx_in  = idx_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         x_in    = x_start;
         y_in    = y_start;
         z_in    = '0;
         idx_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_in = x_ff + (y_ff >>> idx_ff);
            y_in = y_ff - (x_ff >>> idx_ff);
            z_in = z_ff + step_ang;
         end else begin
            x_in = x_ff - (y_ff >>> idx_ff);
            y_in = y_ff + (x_ff >>> idx_ff);
            z_in = z_ff - step_ang;
         end
         idx_in = idx_ff + 1'b1;
         if (idx_ff == IW'(N - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         idx_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         idx_ff  <= idx_in;
      end
      x_ff <= x_in;
      y_ff <= y_in;
      z_ff <= z_in;
   end

   assign busy  = busy_ff;
   assign done  = done_ff;
   assign x_out = x_ff;
   assign z_out = z_ff;

endmodule

### src/tcf_div.sv
// ----------------------------------------------------------------------------
// tcf_div
// Gyro increments: rate * period * 4096 / 1000 by reciprocal multiplication,
// in a coarse, a remainder and a fine step per axis.
// ----------------------------------------------------------------------------
module tcf_div (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   input  logic signed [15:0]                gyro_a,
   input  logic signed [15:0]                gyro_b,
   input  logic [9:0]                        period,
   output logic                              busy,
   output logic signed [tcf_pkg::INC_W-1:0]  inc_a,
   output logic signed [tcf_pkg::INC_W-1:0]  inc_b
);
   import tcf_pkg::*;

   typedef enum logic [1:0] {
      D_IDLE, D_COARSE, D_REM, D_FINE
   } phase_type;

   // floor(n / 125) = (n * RECIP_HI) >> 33 for n below 2^26
   localparam logic [26:0] RECIP_HI = 27'd68719477;
   // floor(n / 125) = (n * RECIP_LO) >> 23 for n below 2^16
   localparam logic [16:0] RECIP_LO = 17'd67109;
   localparam logic [6:0]  DIVISOR  = 7'd125;

   phase_type                 phase_ff, phase_in;
   logic                      second_ff, second_in;
   logic [25:0]               mag_ff, mag_in;
   logic                      neg_ff, neg_in;
   logic [19:0]               q_hi_ff, q_hi_in;
   logic [6:0]                rem_ff, rem_in;
   logic signed [15:0]        gyro_b_ff, gyro_b_in;
   logic signed [INC_W-1:0]   inc_a_ff, inc_a_in, inc_b_ff, inc_b_in;
   logic signed [15:0]        gsel;
   logic signed [26:0]        prod;
   logic [25:0]               mag;
   logic [52:0]               hi_p;
   logic [26:0]               q_mul;
   logic [32:0]               lo_p;
   logic [27:0]               q_full;
   logic signed [INC_W-1:0]   qs;

   always_comb begin
      gsel   = start ? gyro_a : gyro_b_ff;
      prod   = 27'(gsel) * $signed({17'd0, period});
      mag    = prod[26] ? 26'(-prod) : prod[25:0];
      hi_p   = {27'd0, mag_ff} * {26'd0, RECIP_HI};
      q_mul  = 27'(q_hi_ff) * 27'(DIVISOR);
      lo_p   = 33'({rem_ff, 9'd0}) * 33'(RECIP_LO);
      // |rate * period| * 512 / 125 split as 512 * (m / 125) + 512 * (m % 125) / 125
      q_full = 28'({q_hi_ff, 9'd0}) + 28'(lo_p[31:23]);
      qs     = $signed(INC_W'(q_full));
   end

   always_comb begin
      phase_in  = phase_ff;
      second_in = second_ff;
      mag_in    = mag_ff;
      neg_in    = neg_ff;
      q_hi_in   = q_hi_ff;
      rem_in    = rem_ff;
      gyro_b_in = gyro_b_ff;
      inc_a_in  = inc_a_ff;
      inc_b_in  = inc_b_ff;
      if (start) begin
         phase_in  = D_COARSE;
         second_in = 1'b0;
         gyro_b_in = gyro_b;
         mag_in    = mag;
         neg_in    = prod[26];
      end else begin
         unique case (phase_ff)
            D_IDLE: ;
            D_COARSE: begin
               q_hi_in  = hi_p[52:33];
               phase_in = D_REM;
            end
            D_REM: begin
               rem_in   = 7'(mag_ff - q_mul[25:0]);
               phase_in = D_FINE;
            end
            D_FINE: begin
               if (!second_ff) begin
                  inc_a_in  = neg_ff ? -qs : qs;
                  second_in = 1'b1;
                  mag_in    = mag;
                  neg_in    = prod[26];
                  phase_in  = D_COARSE;
               end else begin
                  inc_b_in = neg_ff ? -qs : qs;
                  phase_in = D_IDLE;
               end
            end
            default: phase_in = D_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= D_IDLE;
      end else begin
         phase_ff <= phase_in;
      end
      second_ff <= second_in;
      mag_ff    <= mag_in;
      neg_ff    <= neg_in;
      q_hi_ff   <= q_hi_in;
      rem_ff    <= rem_in;
      gyro_b_ff <= gyro_b_in;
      inc_a_ff  <= inc_a_in;
      inc_b_ff  <= inc_b_in;
   end

   assign busy  = (phase_ff != D_IDLE);
   assign inc_a = inc_a_ff;
   assign inc_b = inc_b_ff;

endmodule

### src/tilt_complementary_filter.sv
// ----------------------------------------------------------------------------
// tilt_complementary_filter
// Roll and pitch from accelerometer tilt blended with integrated gyro rate.
// ----------------------------------------------------------------------------
// Each accepted request gives one result; CORDIC step counts above 24 act as 24.
// The work is four passes through the single CORDIC unit (a magnitude and an
// angle pass for roll, then for pitch), one numerator multiply per axis, a
// wait state that picks up the gyro increments (whose small divider finishes
// long before) and three blend steps per axis. An axis whose numerator is zero
// skips its angle pass. The block takes no new request until the result has
// been taken and accepts the next one the cycle after, so it never starts a
// request before it is through with the last one.
module tilt_complementary_filter #(
   parameter int CORDIC_STEPS = tcf_pkg::CORDIC_STEPS_DEF
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  tcf_pkg::tcf_req_type                   req_data,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output tcf_pkg::tcf_rsp_type                   rsp_data,
   input  logic                                   csr_we,
   input  logic [tcf_pkg::CSR_IDX_W-1:0]          csr_index,
   input  logic [tcf_pkg::CSR_DATA_W-1:0]         csr_data
);
   import tcf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_MAG_GO, S_MAG_WAIT, S_NUM, S_ANG_GO, S_ANG_WAIT,
      S_DIV_WAIT, S_BL1, S_BL2, S_BL3, S_OUT
   } state_type;

   localparam logic signed [17:0] GAIN_Q16 = 18'sd107922;
   localparam logic [16:0]        ONE_Q16  = 17'd65536;

   state_type                 state_ff, state_in;
   logic                      sel_ff, sel_in;
   logic [16:0]               blend_ff, blend_in;
   logic [9:0]                period_ff, period_in;
   tcf_req_type               req_ff, req_in;
   logic signed [CORDIC_W-1:0] yv_ff, yv_in;
   logic signed [ANGLE_W-1:0] acc_ff [2];
   logic signed [ANGLE_W-1:0] acc_in [2];
   logic signed [23:0]        roll_ff, roll_in, pitch_ff, pitch_in;
   logic signed [51:0]        prod_ff, prod_in;
   logic signed [51:0]        sum_ff, sum_in;

   logic                      req_acc;
   logic                      cord_start, cord_busy, cord_done;
   logic signed [CORDIC_W-1:0] cx0, cy0, cx;
   logic signed [ANGLE_W-1:0] cz;
   logic                      div_busy;
   logic signed [INC_W-1:0]   inc_x, inc_y;

   logic signed [16:0]        num, a_ext, b_ext;
   logic [16:0]               a_abs, b_abs, alpha;
   logic signed [33:0]        mul_a;
   logic signed [17:0]        mul_b;
   logic signed [51:0]        mul_p;
   logic signed [32:0]        pred;
   logic signed [23:0]        est;
   logic signed [27:0]        rnd;
   logic signed [23:0]        sat;

   assign req_acc   = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign rsp_data.roll_angle  = roll_ff;
   assign rsp_data.pitch_angle = pitch_ff;

   // operands of the current axis
   always_comb begin
      if (!sel_ff) begin
         num   = 17'(req_ff.accel_y);
         a_ext = 17'(req_ff.accel_x);
      end else begin
         num   = -17'(req_ff.accel_x);
         a_ext = 17'(req_ff.accel_y);
      end
      b_ext = 17'(req_ff.accel_z);
      a_abs = a_ext[16] ? 17'(-a_ext) : a_ext;
      b_abs = b_ext[16] ? 17'(-b_ext) : b_ext;
      alpha = (blend_ff > ONE_Q16) ? ONE_Q16 : blend_ff;
      est   = sel_ff ? pitch_ff : roll_ff;
      pred  = 33'($signed({est, 8'd0})) + 33'(sel_ff ? inc_y : inc_x);
   end

   always_comb begin
      cord_start = (state_ff == S_MAG_GO) || ((state_ff == S_ANG_GO) && (yv_ff != '0));
      if (state_ff == S_MAG_GO) begin
         cx0 = $signed({3'd0, a_abs, 8'd0});
         cy0 = $signed({3'd0, b_abs, 8'd0});
      end else begin
         cx0 = cx;
         cy0 = yv_ff;
      end
   end

   // one shared multiplier
   always_comb begin
      unique case (state_ff)
         S_BL1: begin
            mul_a = 34'(pred);
            mul_b = $signed({1'b0, alpha});
         end
         S_BL2: begin
            mul_a = 34'(acc_ff[sel_ff]);
            mul_b = $signed({1'b0, 17'(ONE_Q16 - alpha)});
         end
         default: begin
            mul_a = 34'(num);
            mul_b = GAIN_Q16;
         end
      endcase
      mul_p = mul_a * mul_b;
      rnd   = sum_ff[51:24];
      if (rnd > 28'sd8388607) begin
         sat = 24'sd8388607;
      end else if (rnd < -28'sd8388608) begin
         sat = -24'sd8388608;
      end else begin
         sat = rnd[23:0];
      end
   end

   always_comb begin
      state_in  = state_ff;
      sel_in    = sel_ff;
      blend_in  = blend_ff;
      period_in = period_ff;
      req_in    = req_ff;
      yv_in     = yv_ff;
      acc_in    = acc_ff;
      roll_in   = roll_ff;
      pitch_in  = pitch_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      if (csr_we) begin
         if (csr_index == CSR_BLEND) begin
            blend_in = csr_data;
         end else if (csr_index == CSR_PERIOD) begin
            period_in = csr_data[9:0];
         end
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_acc) begin
               req_in   = req_data;
               sel_in   = 1'b0;
               state_in = S_MAG_GO;
            end
         end
         S_MAG_GO: state_in = S_MAG_WAIT;
         S_MAG_WAIT: begin
            if (cord_done) state_in = S_NUM;
         end
         S_NUM: begin
            yv_in    = mul_p[35:8];
            state_in = S_ANG_GO;
         end
         S_ANG_GO: begin
            if (yv_ff == '0) begin
               // zero numerator gives exactly zero
               acc_in[sel_ff] = '0;
               sel_in         = 1'b1;
               state_in       = sel_ff ? S_DIV_WAIT : S_MAG_GO;
               if (sel_ff) sel_in = 1'b0;
            end else begin
               state_in = S_ANG_WAIT;
            end
         end
         S_ANG_WAIT: begin
            if (cord_done) begin
               acc_in[sel_ff] = cz;
               sel_in         = !sel_ff;
               state_in       = sel_ff ? S_DIV_WAIT : S_MAG_GO;
            end
         end
         S_DIV_WAIT: begin
            if (!div_busy) state_in = S_BL1;
         end
         S_BL1: begin
            prod_in  = mul_p;
            state_in = S_BL2;
         end
         S_BL2: begin
            sum_in   = prod_ff + mul_p + 52'sd8388608;
            state_in = S_BL3;
         end
         S_BL3: begin
            if (sel_ff) begin
               pitch_in = sat;
               sel_in   = 1'b0;
               state_in = S_OUT;
            end else begin
               roll_in  = sat;
               sel_in   = 1'b1;
               state_in = S_BL1;
            end
         end
         S_OUT: begin
            if (!rsp_stall) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         sel_ff    <= 1'b0;
         blend_ff  <= 17'd64225;
         period_ff <= 10'd10;
         roll_ff   <= '0;
         pitch_ff  <= '0;
      end else begin
         state_ff  <= state_in;
         sel_ff    <= sel_in;
         blend_ff  <= blend_in;
         period_ff <= period_in;
         roll_ff   <= roll_in;
         pitch_ff  <= pitch_in;
      end
      req_ff  <= req_in;
      yv_ff   <= yv_in;
      acc_ff  <= acc_in;
      prod_ff <= prod_in;
      sum_ff  <= sum_in;
   end

   tcf_cordic #(
      .STEPS(CORDIC_STEPS)
   ) u_cordic (
      .clock   (clock),
      .reset   (reset),
      .start   (cord_start),
      .x_start (cx0),
      .y_start (cy0),
      .busy    (cord_busy),
      .done    (cord_done),
      .x_out   (cx),
      .z_out   (cz)
   );

   tcf_div u_div (
      .clock  (clock),
      .reset  (reset),
      .start  (req_acc),
      .gyro_a (req_data.gyro_x),
      .gyro_b (req_data.gyro_y),
      .period (period_ff),
      .busy   (div_busy),
      .inc_a  (inc_x),
      .inc_b  (inc_y)
   );

   a_rsp_blocks_req: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("request accepted while result pending");

   a_cordic_free: assert property (@(posedge clock) disable iff (reset)
      cord_start |-> !cord_busy)
      else $error("cordic restarted while busy");

   a_div_done: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BL1) |-> !div_busy)
      else $error("blend started before gyro increments ready");

   a_reset_est: assert property (@(posedge clock)
      $past(reset) |-> (roll_ff == '0 && pitch_ff == '0))
      else $error("estimates not cleared by reset");

endmodule
